FILE: rtl/lfps_pkg.sv
// Shared widths, register indexes and word layouts for the line follower PID steering block.
package lfps_pkg;

    // Sample and integrator widths
    localparam int SAMPLE_BITS = 10;
    localparam int SUM_BITS    = 13;

    // Register widths
    localparam int GAIN_W = 12;
    localparam int BASE_W = 15;
    localparam int THR_W  = 10;
    localparam int CFG_W  = 15;
    localparam int ADDR_W = 3;

    // Result field widths
    localparam int ERR_W   = 3;
    localparam int DRIVE_W = 16;

    // Compare width for sample against threshold
    localparam int CMP_W = (SAMPLE_BITS > THR_W) ? SAMPLE_BITS : THR_W;

    // Arithmetic widths: P and D products, I product, full correction, drive sum
    localparam int DIFF_W  = ERR_W + 1;
    localparam int P_W     = GAIN_W + 1 + ERR_W;
    localparam int D_W     = GAIN_W + 1 + DIFF_W;
    localparam int I_W     = GAIN_W + 1 + SUM_BITS;
    localparam int CORR_W  = I_W + 2;
    localparam int DSUM_W  = CORR_W + 1;

    // Integrator limit is +-(2^(SUM_BITS-1)-1)
    localparam logic signed [SUM_BITS:0] SUM_LIM = (SUM_BITS + 1)'((1 << (SUM_BITS - 1)) - 1);

    // Drive saturation bounds
    localparam logic signed [DSUM_W-1:0] DRIVE_MAX = DSUM_W'((1 << (DRIVE_W - 1)) - 1);
    localparam logic signed [DSUM_W-1:0] DRIVE_MIN = -DSUM_W'(1 << (DRIVE_W - 1));

    // Stream word widths, padded to whole bytes
    localparam int IN_BITS  = 5 * SAMPLE_BITS;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * DRIVE_W + ERR_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // Register indexes
    typedef enum logic [ADDR_W-1:0] {
        REG_PROP_GAIN  = 3'd0,
        REG_INTEG_GAIN = 3'd1,
        REG_DERIV_GAIN = 3'd2,
        REG_BASE_DRIVE = 3'd3,
        REG_LINE_THR   = 3'd4
    } reg_idx_t;

    // Register reset values
    localparam logic [GAIN_W-1:0] PROP_GAIN_RST  = GAIN_W'(438);
    localparam logic [GAIN_W-1:0] INTEG_GAIN_RST = GAIN_W'(0);
    localparam logic [GAIN_W-1:0] DERIV_GAIN_RST = GAIN_W'(384);
    localparam logic [BASE_W-1:0] BASE_DRIVE_RST = BASE_W'(1664);
    localparam logic [THR_W-1:0]  LINE_THR_RST   = THR_W'(400);

endpackage

FILE: rtl/line_follow_pid_steering.sv
// Top level: five-sensor line decode, PID correction and wheel drive selection.
// Path from an accepted input word to m_axis_tvalid: input register, then result register.
// One word per cycle unless stalled; decode, integrator update, three gain multiplies share one stage.
// The integrator and previous error advance as each word moves into the result register.
// Reset (aresetn low, synchronous) empties both stages, clears error state, reloads register defaults.
module line_follow_pid_steering (
    input  logic                          aclk,
    input  logic                          aresetn,
    // Configuration write port
    input  logic                          cfg_wr_en,
    input  logic [lfps_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [lfps_pkg::CFG_W-1:0]    cfg_wdata,
    // Sample stream
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // fields from bit 0: far_left_sample, left_sample, mid_sample, right_sample,
    // far_right_sample, zero pad
    input  logic [lfps_pkg::IN_W-1:0]     s_axis_tdata,
    // Drive stream
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // fields from bit 0: left_drive, right_drive, line_error, zero pad
    output logic [lfps_pkg::OUT_W-1:0]    m_axis_tdata
);

    localparam int SB = lfps_pkg::SAMPLE_BITS;

    // Configuration registers
    logic [lfps_pkg::GAIN_W-1:0] prop_gain_reg;
    logic [lfps_pkg::GAIN_W-1:0] integ_gain_reg;
    logic [lfps_pkg::GAIN_W-1:0] deriv_gain_reg;
    logic [lfps_pkg::BASE_W-1:0] base_drive_reg;
    logic [lfps_pkg::THR_W-1:0]  line_thr_reg;

    // Pipeline registers
    logic                        in_valid_reg;
    logic [lfps_pkg::IN_BITS-1:0] samples_reg;
    logic                        out_valid_reg;
    logic signed [lfps_pkg::DRIVE_W-1:0] left_reg;
    logic signed [lfps_pkg::DRIVE_W-1:0] right_reg;
    logic signed [lfps_pkg::ERR_W-1:0]   err_out_reg;

    // Controller state
    logic signed [lfps_pkg::ERR_W-1:0]    prev_err_reg;
    logic signed [lfps_pkg::SUM_BITS-1:0] err_sum_reg;

    // Datapath signals
    logic        advance;
    logic        out_free;
    logic [4:0]  sees;
    logic        fl, l, m, r, fr;
    logic signed [lfps_pkg::ERR_W-1:0]    err_next;
    logic signed [lfps_pkg::SUM_BITS:0]   sum_raw;
    logic signed [lfps_pkg::SUM_BITS-1:0] sum_next;
    logic signed [lfps_pkg::DIFF_W-1:0]   diff;
    logic signed [lfps_pkg::P_W-1:0]      p_prod;
    logic signed [lfps_pkg::I_W-1:0]      i_prod;
    logic signed [lfps_pkg::D_W-1:0]      d_prod;
    logic signed [lfps_pkg::CORR_W-1:0]   corr;
    logic signed [lfps_pkg::DSUM_W-1:0]   base_ext;
    logic signed [lfps_pkg::DSUM_W-1:0]   drive_sum;
    logic signed [lfps_pkg::DRIVE_W-1:0]  drive_sat;
    logic signed [lfps_pkg::DRIVE_W-1:0]  base_sat;
    logic signed [lfps_pkg::DRIVE_W-1:0]  left_next;
    logic signed [lfps_pkg::DRIVE_W-1:0]  right_next;

    // Handshake: the result register frees when taken, the input register when it advances
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || advance;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg  <= lfps_pkg::PROP_GAIN_RST;
            integ_gain_reg <= lfps_pkg::INTEG_GAIN_RST;
            deriv_gain_reg <= lfps_pkg::DERIV_GAIN_RST;
            base_drive_reg <= lfps_pkg::BASE_DRIVE_RST;
            line_thr_reg   <= lfps_pkg::LINE_THR_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                lfps_pkg::REG_PROP_GAIN:  prop_gain_reg  <= cfg_wdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_INTEG_GAIN: integ_gain_reg <= cfg_wdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_DERIV_GAIN: deriv_gain_reg <= cfg_wdata[lfps_pkg::GAIN_W-1:0];
                lfps_pkg::REG_BASE_DRIVE: base_drive_reg <= cfg_wdata[lfps_pkg::BASE_W-1:0];
                lfps_pkg::REG_LINE_THR:   line_thr_reg   <= cfg_wdata[lfps_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    // Capture input word
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            samples_reg <= s_axis_tdata[lfps_pkg::IN_BITS-1:0];
        end
    end

    // Threshold each sample
    always_comb begin
        for (int k = 0; k < 5; k++) begin
            sees[k] = lfps_pkg::CMP_W'(samples_reg[k*SB +: SB])
                      < lfps_pkg::CMP_W'(line_thr_reg);
        end
    end

    assign fl = sees[0];
    assign l  = sees[1];
    assign m  = sees[2];
    assign r  = sees[3];
    assign fr = sees[4];

    // Decode line pattern in priority order, hold previous error on no match
    always_comb begin
        err_next = prev_err_reg;
        if (!l && !r && m)
            err_next = 3'sd0;
        else if (!fl && !l && r && !m && !fr)
            err_next = -3'sd1;
        else if (!fl && l && !r && !m && !fr)
            err_next = 3'sd1;
        else if (!fl && !l && !r && !m && fr)
            err_next = -3'sd2;
        else if (fl && !l && !r && !m && !fr)
            err_next = 3'sd2;
        else if (fl && l && !r && m && !fr)
            err_next = 3'sd0;
    end

    // Saturating integrator
    always_comb begin
        sum_raw = (lfps_pkg::SUM_BITS + 1)'(err_sum_reg) + (lfps_pkg::SUM_BITS + 1)'(err_next);
        if (sum_raw > lfps_pkg::SUM_LIM)
            sum_next = lfps_pkg::SUM_BITS'(lfps_pkg::SUM_LIM);
        else if (sum_raw < -lfps_pkg::SUM_LIM)
            sum_next = lfps_pkg::SUM_BITS'(-lfps_pkg::SUM_LIM);
        else
            sum_next = sum_raw[lfps_pkg::SUM_BITS-1:0];
    end

    // Error difference for the derivative term
    assign diff = lfps_pkg::DIFF_W'(err_next) - lfps_pkg::DIFF_W'(prev_err_reg);

    // Gain products and correction
    assign p_prod = $signed({1'b0, prop_gain_reg})  * err_next;
    assign i_prod = $signed({1'b0, integ_gain_reg}) * sum_next;
    assign d_prod = $signed({1'b0, deriv_gain_reg}) * diff;
    assign corr   = lfps_pkg::CORR_W'(p_prod) + lfps_pkg::CORR_W'(i_prod)
                  + lfps_pkg::CORR_W'(d_prod);

    // Saturate base plus correction and base alone
    assign base_ext  = $signed({{(lfps_pkg::DSUM_W - lfps_pkg::BASE_W){1'b0}}, base_drive_reg});
    assign drive_sum = base_ext + lfps_pkg::DSUM_W'(corr);

    always_comb begin
        if (drive_sum > lfps_pkg::DRIVE_MAX)
            drive_sat = lfps_pkg::DRIVE_W'(lfps_pkg::DRIVE_MAX);
        else if (drive_sum < lfps_pkg::DRIVE_MIN)
            drive_sat = lfps_pkg::DRIVE_W'(lfps_pkg::DRIVE_MIN);
        else
            drive_sat = drive_sum[lfps_pkg::DRIVE_W-1:0];
    end

    assign base_sat = (base_ext > lfps_pkg::DRIVE_MAX) ? lfps_pkg::DRIVE_W'(lfps_pkg::DRIVE_MAX)
                                                       : base_ext[lfps_pkg::DRIVE_W-1:0];

    // Steer: correction sign picks the driven side
    always_comb begin
        if (corr > 0) begin
            left_next  = drive_sat;
            right_next = '0;
        end else if (corr < 0) begin
            left_next  = '0;
            right_next = drive_sat;
        end else begin
            left_next  = base_sat;
            right_next = base_sat;
        end
    end

    // Advance controller state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_err_reg <= '0;
            err_sum_reg  <= '0;
        end else if (advance) begin
            prev_err_reg <= err_next;
            err_sum_reg  <= sum_next;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            left_reg    <= left_next;
            right_reg   <= right_next;
            err_out_reg <= err_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(lfps_pkg::OUT_W - lfps_pkg::OUT_BITS){1'b0}},
                            err_out_reg, right_reg, left_reg};

endmodule

FILE: rtl/lfps_checker.sv
// Port checker for the line follower PID steering block, with its bind.
module lfps_port_props (
    input logic                       aclk,
    input logic                       aresetn,
    input logic                       m_axis_tvalid,
    input logic                       m_axis_tready,
    input logic [lfps_pkg::OUT_W-1:0] m_axis_tdata
);

    logic [lfps_pkg::DRIVE_W-1:0] left_w;
    logic [lfps_pkg::DRIVE_W-1:0] right_w;
    logic [lfps_pkg::ERR_W-1:0]   err_w;

    assign left_w  = m_axis_tdata[lfps_pkg::DRIVE_W-1:0];
    assign right_w = m_axis_tdata[2*lfps_pkg::DRIVE_W-1:lfps_pkg::DRIVE_W];
    assign err_w   = m_axis_tdata[lfps_pkg::OUT_BITS-1:2*lfps_pkg::DRIVE_W];

    // Reset empties the result side
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_axis_tvalid)
        else $error("result word valid right after reset");

    // Stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result word changed");

    // Line error stays within -2..2
    a_err_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> err_w != 3'b011 && err_w != 3'b100 && err_w != 3'b101)
        else $error("line error out of range");

    // Only one side driven unless both carry base
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> left_w == '0 || right_w == '0 || left_w == right_w)
        else $error("both sides driven with different speeds");

endmodule

bind line_follow_pid_steering lfps_port_props u_lfps_port_props (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

FILE: verif/lfps_checker.sv
`timescale 1ns / 1ps
// Stream checker: mirrors the register file, predicts each drive word and compares it field by field.
module lfps_checker
    import lfps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]  cfg_wdata,
    input  logic              s_axis_tvalid,
    input  logic              s_axis_tready,
    // fields from bit 0: far_left_sample, left_sample, mid_sample, right_sample,
    // far_right_sample, zero pad
    input  logic [IN_W-1:0]   s_axis_tdata,
    input  logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // fields from bit 0: left_drive, right_drive, line_error, zero pad
    input  logic [OUT_W-1:0]  m_axis_tdata,
    output int                mismatch_count,
    output int                pending_count,
    output int                result_count
);

    localparam int  SUM_MAX   = 2 ** (SUM_BITS - 1) - 1;
    localparam longint DRV_HI = 2 ** (DRIVE_W - 1) - 1;
    localparam longint DRV_LO = -(2 ** (DRIVE_W - 1));

    typedef struct packed {
        logic signed [DRIVE_W-1:0] left;
        logic signed [DRIVE_W-1:0] right;
        logic signed [ERR_W-1:0]   err;
    } drive_word_t;

    // Mirrored registers and controller state
    int prop_k;
    int integ_k;
    int deriv_k;
    int base_k;
    int thr_k;
    int prev_err;
    int err_sum;

    drive_word_t drive_q[$];
    drive_word_t want;
    drive_word_t got;

    initial begin
        mismatch_count = 0;
        pending_count  = 0;
        result_count   = 0;
    end

    function automatic longint clip_drive(input longint v);
        if (v > DRV_HI) return DRV_HI;
        if (v < DRV_LO) return DRV_LO;
        return v;
    endfunction

    // Decode the sensor pattern, advance the PID state and form the wheel drives
    function automatic drive_word_t steer_tick(input logic [IN_W-1:0] w);
        logic [4:0]  on;
        int          e;
        int          nsum;
        int          dlt;
        longint      corr;
        longint      lft;
        longint      rgt;
        drive_word_t r;
        for (int i = 0; i < 5; i++) begin
            on[i] = int'(w[i*SAMPLE_BITS +: SAMPLE_BITS]) < thr_k;
        end
        // bit order: far left, left, mid, right, far right; first match wins
        e = prev_err;
        if (!on[1] && !on[3] && on[2]) e = 0;
        else if (!on[0] && !on[1] && on[3] && !on[2] && !on[4]) e = -1;
        else if (!on[0] && on[1] && !on[3] && !on[2] && !on[4]) e = 1;
        else if (!on[0] && !on[1] && !on[3] && !on[2] && on[4]) e = -2;
        else if (on[0] && !on[1] && !on[3] && !on[2] && !on[4]) e = 2;
        else if (on[0] && on[1] && !on[3] && on[2] && !on[4]) e = 0;

        // saturate the integrator, this tick's error included
        nsum = err_sum + e;
        if (nsum > SUM_MAX) nsum = SUM_MAX;
        if (nsum < -SUM_MAX) nsum = -SUM_MAX;
        dlt      = e - prev_err;
        prev_err = e;
        err_sum  = nsum;

        corr = longint'(prop_k) * longint'(e) + longint'(integ_k) * longint'(nsum)
             + longint'(deriv_k) * longint'(dlt);

        // sign of the correction picks the driven side
        if (corr > 0) begin
            lft = clip_drive(longint'(base_k) + corr);
            rgt = 0;
        end else if (corr < 0) begin
            lft = 0;
            rgt = clip_drive(longint'(base_k) + corr);
        end else begin
            lft = clip_drive(longint'(base_k));
            rgt = lft;
        end

        r.left  = lft[DRIVE_W-1:0];
        r.right = rgt[DRIVE_W-1:0];
        r.err   = e[ERR_W-1:0];
        return r;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            prop_k   = PROP_GAIN_RST;
            integ_k  = INTEG_GAIN_RST;
            deriv_k  = DERIV_GAIN_RST;
            base_k   = BASE_DRIVE_RST;
            thr_k    = LINE_THR_RST;
            prev_err = 0;
            err_sum  = 0;
            drive_q.delete();
        end else begin
            // mirror register writes, drop unknown indexes
            if (cfg_wr_en) begin
                case (cfg_addr)
                    REG_PROP_GAIN:  prop_k  = cfg_wdata[GAIN_W-1:0];
                    REG_INTEG_GAIN: integ_k = cfg_wdata[GAIN_W-1:0];
                    REG_DERIV_GAIN: deriv_k = cfg_wdata[GAIN_W-1:0];
                    REG_BASE_DRIVE: base_k  = cfg_wdata[BASE_W-1:0];
                    REG_LINE_THR:   thr_k   = cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready) drive_q.push_back(steer_tick(s_axis_tdata));

            // compare each drive word with the oldest prediction
            if (m_axis_tvalid && m_axis_tready) begin
                result_count++;
                got.left  = m_axis_tdata[DRIVE_W-1:0];
                got.right = m_axis_tdata[2*DRIVE_W-1:DRIVE_W];
                got.err   = m_axis_tdata[2*DRIVE_W +: ERR_W];
                if (drive_q.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected drive word left=%0d right=%0d err=%0d",
                                 $realtime, got.left, got.right, got.err);
                end else begin
                    want = drive_q.pop_front();
                    if (got.left !== want.left || got.right !== want.right
                        || got.err !== want.err) begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display({"%0t: drive word %0d mismatch: exp left=%0d right=%0d ",
                                      "err=%0d, got left=%0d right=%0d err=%0d"},
                                     $realtime, result_count, want.left, want.right,
                                     want.err, got.left, got.right, got.err);
                    end
                end
            end
        end
        pending_count = drive_q.size();
    end

endmodule

FILE: verif/tb_line_follow_pid_steering.sv
`timescale 1ns / 1ps
// Testbench top: clock, reset, register settings, sample stimulus, back-pressure and verdict.
module tb_line_follow_pid_steering;
    import lfps_pkg::*;

    localparam int SAMPLE_MAX = 2 ** SAMPLE_BITS - 1;

    // Which sensors see the line, bit order far left .. far right
    localparam logic [4:0] SEEN_NONE       = 5'b00000;
    localparam logic [4:0] SEEN_ALL        = 5'b11111;
    localparam logic [4:0] SEEN_FAR_LEFT   = 5'b00001;
    localparam logic [4:0] SEEN_LEFT       = 5'b00010;
    localparam logic [4:0] SEEN_CENTER     = 5'b00100;
    localparam logic [4:0] SEEN_RIGHT      = 5'b01000;
    localparam logic [4:0] SEEN_FAR_RIGHT  = 5'b10000;
    localparam logic [4:0] SEEN_OUTER      = 5'b10001;
    localparam logic [4:0] SEEN_LEFT_RUN   = 5'b00111;
    localparam logic [4:0] SEEN_RIGHT_PAIR = 5'b11000;

    localparam logic [4:0] DIRECTED_MASKS [10] = '{
        SEEN_NONE, SEEN_CENTER, SEEN_RIGHT, SEEN_LEFT, SEEN_FAR_RIGHT,
        SEEN_FAR_LEFT, SEEN_LEFT_RUN, SEEN_ALL, SEEN_CENTER | SEEN_OUTER, SEEN_RIGHT_PAIR
    };

    typedef enum {PICK_RANDOM, PICK_EDGE, PICK_EXTREME} sample_pick_t;

    logic              aclk          = 1'b0;
    logic              aresetn       = 1'b0;
    logic              cfg_wr_en     = 1'b0;
    logic [ADDR_W-1:0] cfg_addr      = '0;
    logic [CFG_W-1:0]  cfg_wdata     = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    int mismatch_count;
    int pending_count;
    int result_count;

    int          gap_pct   = 0;
    int          stall_pct = 0;
    bit          hold_req  = 1'b0;
    int unsigned cur_thr   = LINE_THR_RST;
    int          sent      = 0;
    int          settings_used = 1;

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    line_follow_pid_steering i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    lfps_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_addr       (cfg_addr),
        .cfg_wdata      (cfg_wdata),
        .s_axis_tvalid  (s_axis_tvalid),
        .s_axis_tready  (s_axis_tready),
        .s_axis_tdata   (s_axis_tdata),
        .m_axis_tvalid  (m_axis_tvalid),
        .m_axis_tready  (m_axis_tready),
        .m_axis_tdata   (m_axis_tdata),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count),
        .result_count   (result_count)
    );

    // Build one sample set: seen sensors below the threshold, the rest at or above it
    function automatic logic [IN_BITS-1:0] build_word(input logic [4:0] mask,
                                                       input sample_pick_t pick);
        logic [IN_BITS-1:0] w;
        int unsigned        v;
        w = '0;
        for (int i = 0; i < 5; i++) begin
            if (mask[i] && cur_thr > 0) begin
                if (pick == PICK_EXTREME) v = 0;
                else if (pick == PICK_EDGE) v = cur_thr - 1;
                else v = $urandom_range(0, cur_thr - 1);
            end else begin
                if (pick == PICK_EXTREME) v = SAMPLE_MAX;
                else if (pick == PICK_EDGE) v = cur_thr;
                else v = $urandom_range(cur_thr, SAMPLE_MAX);
            end
            w[i*SAMPLE_BITS +: SAMPLE_BITS] = v[SAMPLE_BITS-1:0];
        end
        return w;
    endfunction

    // Mostly decodable patterns with random content, some odd masks, some raw noise
    function automatic logic [IN_BITS-1:0] random_set();
        logic [IN_BITS-1:0] w;
        logic [4:0]         mask;
        sample_pick_t       pick;
        int                 r;
        r    = $urandom_range(0, 99);
        pick = ($urandom_range(0, 9) == 0) ? PICK_EDGE : PICK_RANDOM;
        if (r < 75) begin
            case ($urandom_range(0, 5))
                0:       mask = SEEN_CENTER | (5'($urandom) & SEEN_OUTER);
                1:       mask = SEEN_RIGHT;
                2:       mask = SEEN_LEFT;
                3:       mask = SEEN_FAR_RIGHT;
                4:       mask = SEEN_FAR_LEFT;
                default: mask = SEEN_LEFT_RUN;
            endcase
            w = build_word(mask, pick);
        end else if (r < 90) begin
            w = build_word(5'($urandom), pick);
        end else begin
            for (int i = 0; i < 5; i++)
                w[i*SAMPLE_BITS +: SAMPLE_BITS] = SAMPLE_BITS'($urandom_range(0, SAMPLE_MAX));
        end
        return w;
    endfunction

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic load_regs(input logic [CFG_W-1:0] kp, input logic [CFG_W-1:0] ki,
                             input logic [CFG_W-1:0] kd, input logic [CFG_W-1:0] base,
                             input logic [CFG_W-1:0] thr);
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_BASE_DRIVE, base);
        write_reg(REG_LINE_THR, thr);
        cur_thr = thr[THR_W-1:0];
        settings_used++;
    endtask

    // Writes past the register list must leave every register alone
    task automatic poke_unused_regs();
        for (int a = REG_LINE_THR + 1; a < 2 ** ADDR_W; a++)
            write_reg(ADDR_W'(a), CFG_W'($urandom));
    endtask

    // Offer one word and hold it until accepted; then maybe idle for a burst
    task automatic offer_samples(input logic [IN_BITS-1:0] w);
        @(negedge aclk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= IN_W'(w);
        do @(posedge aclk); while (!s_axis_tready);
        sent++;
        if (gap_pct > 0 && $urandom_range(0, 99) < gap_pct) begin
            @(negedge aclk);
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(0, 12)) @(negedge aclk);
        end
    endtask

    // Drop valid and wait until every predicted drive word has come out
    task automatic wait_drained();
        @(negedge aclk);
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    function automatic logic [CFG_W-1:0] pick_reg_value(input int unsigned top);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return CFG_W'($urandom_range(0, top));
        endcase
    endfunction

    // Drive ready: random stall bursts, or one long hold-off on request
    initial begin
        @(posedge aresetn);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (80) @(negedge aclk);
            end else if (stall_pct > 0 && $urandom_range(0, 99) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end else begin
                m_axis_tready <= 1'b1;
                @(negedge aclk);
            end
        end
    end

    // Run limit
    initial begin
        #1_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial begin
        int fail_total;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Reset defaults: every pattern at sample extremes and at the threshold edge
        gap_pct   = 20;
        stall_pct = 20;
        foreach (DIRECTED_MASKS[k]) begin
            offer_samples(build_word(DIRECTED_MASKS[k], PICK_EXTREME));
            offer_samples(build_word(DIRECTED_MASKS[k], PICK_EDGE));
        end

        // Registers at their top, upper write bits set: positive corrections saturate the drive high
        wait_drained();
        load_regs('1, '1, '1, '1, '1);
        offer_samples(build_word(SEEN_FAR_LEFT, PICK_EXTREME));
        offer_samples(build_word(SEEN_FAR_RIGHT, PICK_EXTREME));
        offer_samples(build_word(SEEN_FAR_LEFT, PICK_RANDOM));
        offer_samples(build_word(SEEN_CENTER, PICK_EXTREME));

        // All registers zero: nothing sees the line, zero correction
        wait_drained();
        load_regs('0, '0, '0, '0, '0);
        repeat (3) offer_samples(build_word(5'($urandom), PICK_RANDOM));

        // Integral path alone: the error sum builds up, then swings back through zero
        wait_drained();
        load_regs('0, 15'd1, '0, 15'd100, 15'd400);
        poke_unused_regs();
        gap_pct   = 0;
        stall_pct = 0;
        repeat (15) offer_samples(build_word(SEEN_FAR_LEFT, PICK_RANDOM));
        repeat (30) offer_samples(build_word(SEEN_FAR_RIGHT, PICK_RANDOM));

        // Random phases, each under its own register setting
        for (int p = 0; p < 8; p++) begin
            wait_drained();
            load_regs(pick_reg_value(2 ** CFG_W - 1), pick_reg_value(2 ** CFG_W - 1),
                      pick_reg_value(2 ** CFG_W - 1), pick_reg_value(2 ** CFG_W - 1),
                      ($urandom_range(0, 3) == 0) ? pick_reg_value(2 ** CFG_W - 1)
                                                  : CFG_W'($urandom_range(1, SAMPLE_MAX)));
            if ($urandom_range(0, 1) == 1) poke_unused_regs();
            case ($urandom_range(0, 2))
                0:       gap_pct = 0;
                1:       gap_pct = 15;
                default: gap_pct = 40;
            endcase
            case ($urandom_range(0, 2))
                0:       stall_pct = 0;
                1:       stall_pct = 15;
                default: stall_pct = 40;
            endcase
            // long receiver hold-off while words keep coming
            if (p == 2) begin
                hold_req = 1'b1;
                gap_pct  = 0;
            end
            // last phase runs without idling
            if (p == 7) begin
                gap_pct   = 0;
                stall_pct = 0;
            end
            for (int i = 0; i < 100; i++) begin
                if (p == 4 && i == 50) wait_drained();
                offer_samples(random_set());
            end
        end

        wait_drained();
        repeat (6) @(posedge aclk);
        fail_total = mismatch_count + pending_count;
        $display("Summary: %0d sample sets under %0d register settings, %0d drive words checked",
                 sent, settings_used, result_count);
        $display("Summary: pattern decode, hold, integral build-up and drive clipping exercised");
        if (fail_total == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
